@@ src/ps2mct_pkg.sv @@
package ps2mct_pkg;

   // Cursor position width and output field width
   localparam int PS2MCT_POS_WIDTH = 10;
   localparam int OUT_WIDTH        = 10;
   localparam int CFG_WIDTH        = 11;
   localparam int CSR_IDX_WIDTH    = 2;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROWS    = 2'd1;

   localparam logic [CFG_WIDTH-1:0] COLUMNS_RESET = 11'd80;
   localparam logic [CFG_WIDTH-1:0] ROWS_RESET    = 11'd25;

   // Header bit positions
   localparam int HDR_ALWAYS1 = 3;
   localparam int HDR_XSIGN   = 4;
   localparam int HDR_YSIGN   = 5;
   localparam int HDR_XOVF    = 6;
   localparam int HDR_YOVF    = 7;

   // Divide by five: floor(m * 205 / 1024) is exact for m below 1024
   localparam int          SCALE_DIV  = 5;
   localparam logic [7:0]  DIV5_MUL   = 8'd205;
   localparam int          DIV5_SHIFT = 10;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XBYTE  = 2'd1,
      PH_YBYTE  = 2'd2
   } phase_type;

   // One assembled packet
   typedef struct packed {
      logic       x_sign;
      logic       y_sign;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
   } packet_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

   // Magnitude of the 9-bit signed delta, divided by five
   function automatic logic [5:0] delta_div5(input logic sign, input logic [7:0] b);
      logic [8:0]  mag;
      logic [16:0] prod;
      mag  = sign ? (9'd256 - {1'b0, b}) : {1'b0, b};
      prod = mag * DIV5_MUL;
      return prod[DIV5_SHIFT +: 6];
   endfunction

endpackage

@@ src/ps2mct_front.sv @@
module ps2mct_front
   import ps2mct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] rx_byte
   input  queue_stat_type q_stat,
   output logic           push,
   output packet_type     push_pkt
);

   phase_type  phase_ff, phase_in;
   logic [1:0] signs_ff, signs_in;
   logic [7:0] x_byte_ff, x_byte_in;
   logic       accept;

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   // Packet phase register; held bytes are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
      end else begin
         phase_ff <= phase_in;
      end
      signs_ff  <= signs_in;
      x_byte_ff <= x_byte_in;
   end

   // Classify each byte by phase
   always_comb begin
      phase_in  = phase_ff;
      signs_in  = signs_ff;
      x_byte_in = x_byte_ff;
      push      = 1'b0;
      push_pkt  = '{x_sign: signs_ff[0], y_sign: signs_ff[1],
                    x_byte: x_byte_ff, y_byte: req_tdata};
      if (accept) begin
         case (phase_ff)
            PH_XBYTE: begin
               x_byte_in = req_tdata;
               phase_in  = PH_YBYTE;
            end
            PH_YBYTE: begin
               push     = 1'b1;
               phase_in = PH_HEADER;
            end
            default: begin
               // header: drop on overflow or missing always-one bit
               if (req_tdata[HDR_XOVF] || req_tdata[HDR_YOVF] || !req_tdata[HDR_ALWAYS1]) begin
                  phase_in = PH_HEADER;
               end else begin
                  signs_in = {req_tdata[HDR_YSIGN], req_tdata[HDR_XSIGN]};
                  phase_in = PH_XBYTE;
               end
            end
         endcase
      end
   end

endmodule

@@ src/ps2mct_queue.sv @@
module ps2mct_queue
   import ps2mct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  packet_type     push_pkt,
   input  logic           pop,
   output packet_type     head_pkt,
   output queue_stat_type q_stat
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

   packet_type    entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign q_stat.full      = (count_ff == CW'(QUEUE_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign do_push          = push && !q_stat.full;
   assign do_pop           = pop && q_stat.not_empty;
   assign head_pkt         = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

@@ src/ps2mct_back.sv @@
module ps2mct_back
   import ps2mct_pkg::*;
#(
   parameter int POS_WIDTH = PS2MCT_POS_WIDTH
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_wdata,
   input  packet_type               head_pkt,
   input  queue_stat_type           q_stat,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [4*OUT_WIDTH-1:0]   rsp_tdata
);

   // Signed working width: covers positions, bounds and the sign
   localparam int SW = ((POS_WIDTH > CFG_WIDTH) ? POS_WIDTH : CFG_WIDTH) + 2;
   localparam logic [SW-1:0] POS_MAX = SW'((64'd1 << POS_WIDTH) - 64'd1);

   logic [CFG_WIDTH-1:0]   columns_ff, rows_ff;
   logic [POS_WIDTH-1:0]   col_ff, col_in, row_ff, row_in;
   logic                   out_valid_ff, out_valid_in;
   logic [4*OUT_WIDTH-1:0] out_data_ff, out_data_in;

   logic [5:0]             dx_mag, dy_mag;
   logic signed [SW-1:0]   dx, dy, col_sum, row_sum;
   logic [SW-1:0]          col_bound, row_bound;
   logic [POS_WIDTH-1:0]   new_col, new_row;

   // Bound is size minus one, zero size holds at zero, limited to the position range
   function automatic logic [SW-1:0] bound_of(input logic [CFG_WIDTH-1:0] size);
      logic [SW-1:0] b;
      b = (size == '0) ? '0 : SW'(size - 1'b1);
      return (b > POS_MAX) ? POS_MAX : b;
   endfunction

   function automatic logic [POS_WIDTH-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                                     input logic [SW-1:0] bound);
      logic [POS_WIDTH-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if ($unsigned(v) > bound) begin
         r = bound[POS_WIDTH-1:0];
      end else begin
         r = v[POS_WIDTH-1:0];
      end
      return r;
   endfunction

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= COLUMNS_RESET;
         rows_ff    <= ROWS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMNS: columns_ff <= csr_wdata;
            CSR_ROWS:    rows_ff    <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Take a packet when the output slot is free or being drained
   assign pop = q_stat.not_empty && (!out_valid_ff || rsp_tready);

   // Scaled deltas and clamped positions
   always_comb begin
      dx_mag    = delta_div5(head_pkt.x_sign, head_pkt.x_byte);
      dy_mag    = delta_div5(head_pkt.y_sign, head_pkt.y_byte);
      dx        = head_pkt.x_sign ? -$signed(SW'(dx_mag)) : $signed(SW'(dx_mag));
      dy        = head_pkt.y_sign ? -$signed(SW'(dy_mag)) : $signed(SW'(dy_mag));
      col_sum   = $signed(SW'(col_ff)) + dx;
      row_sum   = $signed(SW'(row_ff)) - dy;
      col_bound = bound_of(columns_ff);
      row_bound = bound_of(rows_ff);
      new_col   = clamp_pos(col_sum, col_bound);
      new_row   = clamp_pos(row_sum, row_bound);
   end

   // Output slot and cursor update
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      if (pop) begin
         col_in       = new_col;
         row_in       = new_row;
         out_valid_in = 1'b1;
         out_data_in  = {OUT_WIDTH'(new_row), OUT_WIDTH'(new_col),
                         OUT_WIDTH'(row_ff), OUT_WIDTH'(col_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ src/ps2_mouse_cursor_tracker.sv @@
// Accepts one received byte per cycle while the packet queue has room.
// After the y delta byte is accepted, the result passes through the packet
// queue, then the registered divide, add and clamp stage. Unless the output
// stalls, sustained rate is one byte per cycle, one result per cycle at most.
// Reset is synchronous: cursor to 0,0, screen to 80 by 25, await a header.
module ps2_mouse_cursor_tracker
   import ps2mct_pkg::*;
#(
   parameter int POS_WIDTH = PS2MCT_POS_WIDTH
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] rx_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [9:0] old_column, [19:10] old_row, [29:20] new_column, [39:30] new_row
   output logic [4*OUT_WIDTH-1:0]   rsp_tdata,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_wdata
);

   queue_stat_type q_stat;
   logic           push, pop;
   packet_type     push_pkt, head_pkt;

   ps2mct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .push       (push),
      .push_pkt   (push_pkt)
   );

   ps2mct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .head_pkt (head_pkt),
      .q_stat   (q_stat)
   );

   ps2mct_back #(
      .POS_WIDTH (POS_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_pkt   (head_pkt),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
   import ps2mct_pkg::*;
;

   // Register indexes with no register behind them; writes must be ignored
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE2 = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SPARE3 = 2'd3;

   // Margin to wait after the last expected move has come out
   localparam int DRAIN_CYCLES = 8;
   // Watchdog limit, far beyond any stall a legal run can have
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTS  = 10;

   // Result fields, old_column in the lowest bits
   typedef struct packed {
      logic [OUT_WIDTH-1:0] new_row;
      logic [OUT_WIDTH-1:0] new_column;
      logic [OUT_WIDTH-1:0] old_row;
      logic [OUT_WIDTH-1:0] old_column;
   } cursor_move_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [7:0]               req_tdata;   // [7:0] rx_byte
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [9:0] old_column, [19:10] old_row, [29:20] new_column, [39:30] new_row
   logic [4*OUT_WIDTH-1:0]   rsp_tdata;
   logic                     csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [CFG_WIDTH-1:0]     csr_wdata;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   cursor_move_type expected_moves[$];
   string           field_names[4] = '{"old_column", "old_row", "new_column", "new_row"};

   // Tracker state as the block should hold it
   phase_type                   pkt_phase;
   logic                        x_neg;
   logic                        y_neg;
   logic [7:0]                  x_hold;
   logic [PS2MCT_POS_WIDTH-1:0] cur_col;
   logic [PS2MCT_POS_WIDTH-1:0] cur_row;
   logic [CFG_WIDTH-1:0]        cols_cfg;
   logic [CFG_WIDTH-1:0]        rows_cfg;

   ps2_mouse_cursor_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // 9-bit signed delta divided by five, toward zero
   function automatic int scale_delta(input logic neg, input logic [7:0] b);
      if (neg) begin
         return -((256 - int'(b)) / SCALE_DIV);
      end
      return int'(b) / SCALE_DIV;
   endfunction

   // Size 0 acts as 1; bound also capped by the position width
   function automatic int clamp_to_screen(input int v, input logic [CFG_WIDTH-1:0] size);
      int bound;
      bound = (size == 0) ? 0 : int'(size) - 1;
      if (bound > (1 << PS2MCT_POS_WIDTH) - 1) begin
         bound = (1 << PS2MCT_POS_WIDTH) - 1;
      end
      if (v < 0) begin
         return 0;
      end
      if (v > bound) begin
         return bound;
      end
      return v;
   endfunction

   // Advance the tracker by one accepted byte; a y byte queues one cursor move
   task automatic track_byte(input logic [7:0] b);
      cursor_move_type mv;
      int              nc;
      int              nr;
      case (pkt_phase)
         PH_XBYTE: begin
            x_hold    = b;
            pkt_phase = PH_YBYTE;
         end
         PH_YBYTE: begin
            nc = clamp_to_screen(int'(cur_col) + scale_delta(x_neg, x_hold), cols_cfg);
            nr = clamp_to_screen(int'(cur_row) - scale_delta(y_neg, b), rows_cfg);
            mv.old_column = cur_col;
            mv.old_row    = cur_row;
            mv.new_column = OUT_WIDTH'(nc);
            mv.new_row    = OUT_WIDTH'(nr);
            expected_moves.push_back(mv);
            cur_col   = PS2MCT_POS_WIDTH'(nc);
            cur_row   = PS2MCT_POS_WIDTH'(nr);
            pkt_phase = PH_HEADER;
         end
         default: begin
            // bad header: overflow set or always-one bit clear
            if (b[HDR_XOVF] || b[HDR_YOVF] || !b[HDR_ALWAYS1]) begin
               pkt_phase = PH_HEADER;
            end else begin
               x_neg     = b[HDR_XSIGN];
               y_neg     = b[HDR_YSIGN];
               pkt_phase = PH_XBYTE;
            end
         end
      endcase
   endtask

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch %0d: %s expected %0d got %0d", mismatch_count, what, want, got);
      end
   endtask

   // Send one request byte; returns at the edge where it is taken
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      track_byte(b);
   endtask

   task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
      send_byte(hdr);
      send_byte(xb);
      send_byte(yb);
   endtask

   // Stop sending and let every expected move come out
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_moves.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] val);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_COLUMNS: cols_cfg = val;
         CSR_ROWS:    rows_cfg = val;
         default: ;
      endcase
   endtask

   function automatic logic [CFG_WIDTH-1:0] pick_size();
      case ($urandom_range(7))
         0:       return CFG_WIDTH'(0);
         1:       return CFG_WIDTH'(1);
         2:       return CFG_WIDTH'(2047);
         3:       return CFG_WIDTH'(1024);
         4:       return CFG_WIDTH'($urandom_range(1, 1024));
         default: return CFG_WIDTH'($urandom_range(1, 100));
      endcase
   endfunction

   function automatic logic [7:0] pick_delta();
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(6))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h04;
            3:       return 8'h05;
            4:       return 8'hFB;
            5:       return 8'hFC;
            default: return 8'hFF;
         endcase
      end
      return 8'($urandom);
   endfunction

   // Header decoding, sign handling and clamping at the reset screen size
   task automatic test_packet_fields();
      send_byte(8'hC8);                   // both overflow bits
      send_byte(8'h48);                   // x overflow
      send_byte(8'h88);                   // y overflow
      send_byte(8'hF7);                   // always-one bit clear
      send_packet(8'h08, 8'hFF, 8'h00);   // +51 columns
      send_packet(8'h08, 8'hFF, 8'h00);   // clamps at right edge
      send_packet(8'h18, 8'h00, 8'h00);   // -51 columns
      send_packet(8'h28, 8'h00, 8'h00);   // row grows, clamps at bottom
      send_packet(8'h0F, 8'h00, 8'hFF);   // buttons set, row to top
      send_packet(8'h38, 8'hFF, 8'hFF);   // -1 truncates to zero
      send_packet(8'h18, 8'h04, 8'h28);   // -50 columns, clamps at left
   endtask

   // Zero, oversized and shrunken screens, and writes to spare indexes
   task automatic test_screen_limits();
      send_packet(8'h28, 8'hFF, 8'h00);
      write_reg(CSR_COLUMNS, CFG_WIDTH'(0));
      write_reg(CSR_ROWS, CFG_WIDTH'(0));
      send_packet(8'h08, 8'hFF, 8'h00);   // old reports stored, new held at 0
      write_reg(CSR_SPARE2, CFG_WIDTH'(5));
      write_reg(CSR_SPARE3, CFG_WIDTH'(2047));
      send_packet(8'h08, 8'h0A, 8'h00);
      write_reg(CSR_COLUMNS, CFG_WIDTH'(2047));
      write_reg(CSR_ROWS, CFG_WIDTH'(1024));
      repeat (22) send_packet(8'h28, 8'hFF, 8'h00);
      write_reg(CSR_COLUMNS, CFG_WIDTH'(1));
      write_reg(CSR_ROWS, CFG_WIDTH'(1));
      send_packet(8'h08, 8'h00, 8'h00);   // cursor beyond the shrunken screen
      write_reg(CSR_COLUMNS, CFG_WIDTH'(1024));
      write_reg(CSR_ROWS, CFG_WIDTH'(2047));
      repeat (22) send_packet(8'h28, 8'hFF, 8'h00);
      write_reg(CSR_COLUMNS, COLUMNS_RESET);
      write_reg(CSR_ROWS, ROWS_RESET);
   endtask

   // Mostly well-formed packets with random content, some noise and cut packets
   task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
      int         sent;
      int         next_cfg;
      int         pick;
      logic [7:0] hdr;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent     = 0;
      next_cfg = 0;
      while (sent < n_items) begin
         if (sent >= next_cfg) begin
            write_reg(CSR_COLUMNS, pick_size());
            write_reg(CSR_ROWS, pick_size());
            next_cfg = sent + $urandom_range(40, 150);
         end
         hdr = 8'($urandom);
         hdr[HDR_ALWAYS1] = 1'b1;
         hdr[HDR_XOVF]    = 1'b0;
         hdr[HDR_YOVF]    = 1'b0;
         pick = $urandom_range(99);
         if (pick < 85) begin
            send_packet(hdr, pick_delta(), pick_delta());
            sent += 3;
         end else if (pick < 93) begin
            send_byte(8'($urandom));
            sent += 1;
         end else begin
            // packet cut short; the next header lands in the y slot
            send_byte(hdr);
            send_byte(pick_delta());
            sent += 2;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result with the oldest expected move
   always @(posedge clock) begin : check_moves
      cursor_move_type got;
      cursor_move_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_moves.size() == 0) begin
            note_mismatch("unexpected move, new_column", -1, int'(got.new_column));
         end else begin
            want = expected_moves.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (got[i*OUT_WIDTH +: OUT_WIDTH] !== want[i*OUT_WIDTH +: OUT_WIDTH]) begin
                  note_mismatch(field_names[i], int'(want[i*OUT_WIDTH +: OUT_WIDTH]),
                                int'(got[i*OUT_WIDTH +: OUT_WIDTH]));
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = 8'h00;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_COLUMNS;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      pkt_phase      = PH_HEADER;
      x_neg          = 1'b0;
      y_neg          = 1'b0;
      x_hold         = 8'h00;
      cur_col        = '0;
      cur_row        = '0;
      cols_cfg       = COLUMNS_RESET;
      rows_cfg       = ROWS_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 61;
      test_packet_fields();
      test_screen_limits();
      test_random_traffic(480, 11, 61);
      test_random_traffic(480, 61, 11);
      test_random_traffic(480, 0, 0);

      wait_drained();
      if (mismatch_count == 0 && expected_moves.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
